FILE: src/utf8_stream_decoder_unit_defines.svh
// Assertion macros for the UTF-8 stream decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check that cons holds in the same cycle as ante
`define UTF8SD_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8sd check failed");
// Check that cons holds in the cycle after ante
`define UTF8SD_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8sd check failed");
`else
`define UTF8SD_ASSERT_IMP(name, clk, rst, ante, cons)
`define UTF8SD_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

FILE: src/utf8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package utf8sd_pkg;

  // Width of the running character total
  localparam int COUNT_WIDTH = 16;

  // Queue between classifier and decoder
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int CP_WIDTH    = 31;
  localparam int UNIT_WIDTH  = 16;
  localparam int FIELD_WIDTH = 16;

  // Token kinds
  localparam logic [1:0] TOK_LEAD = 2'd0;
  localparam logic [1:0] TOK_CONT = 2'd1;
  localparam logic [1:0] TOK_END  = 2'd2;

  // Byte values that end a string when seen as a lead byte
  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_FF  = 8'hff;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [1:0] kind;
    logic       last;     // this byte completes a result
    logic [2:0] len;      // sequence length, lead bytes only
    logic [6:0] payload;  // masked payload bits
  } tok_t;

  // Clamp the running total to the 16-bit result field
  function automatic logic [FIELD_WIDTH-1:0] count_field(input logic [COUNT_WIDTH-1:0] t);
    logic [COUNT_WIDTH+FIELD_WIDTH-1:0] w;
    w = {{FIELD_WIDTH{1'b0}}, t};
    if (|(w >> FIELD_WIDTH)) begin
      return {FIELD_WIDTH{1'b1}};
    end
    return w[FIELD_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/utf8sd_front.sv
// Front end: accepts input bytes and classifies them as lead, continuation or end.
// Depends on utf8sd_pkg; feeds utf8sd_queue.
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,    // [7:0] data_byte
  input  wire logic              q_full,
  output logic                   q_push,
  output utf8sd_pkg::tok_t       q_tok
);
  import utf8sd_pkg::*;

  logic [2:0] pending;
  logic [2:0] pending_next;
  logic [7:0] b;

  assign b        = s_tdata;
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  // Classify the byte against the open sequence
  always_comb begin
    q_tok        = '0;
    pending_next = pending;
    if (pending != 3'd0) begin
      q_tok.kind    = TOK_CONT;
      q_tok.payload = {1'b0, b[5:0]};
      q_tok.last    = (pending == 3'd1);
      pending_next  = pending - 3'd1;
    end else if (b == BYTE_NUL || b == BYTE_FF) begin
      q_tok.kind = TOK_END;
      q_tok.last = 1'b1;
    end else begin
      q_tok.kind = TOK_LEAD;
      priority if (b < 8'h80) begin
        q_tok.len = 3'd1; q_tok.payload = b[6:0];
      end else if (b < 8'he0) begin
        q_tok.len = 3'd2; q_tok.payload = {2'b0, b[4:0]};
      end else if (b < 8'hf0) begin
        q_tok.len = 3'd3; q_tok.payload = {3'b0, b[3:0]};
      end else if (b < 8'hf8) begin
        q_tok.len = 3'd4; q_tok.payload = {4'b0, b[2:0]};
      end else if (b < 8'hfe) begin
        q_tok.len = 3'd5; q_tok.payload = {5'b0, b[1:0]};
      end else begin
        q_tok.len = 3'd6; q_tok.payload = {6'b0, b[0]};
      end
      q_tok.last   = (q_tok.len == 3'd1);
      pending_next = q_tok.len - 3'd1;
    end
  end

  // Advance the continuation count on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else if (q_push) begin
      pending <= pending_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/utf8sd_queue.sv
// Short token queue between the classifier and the decoder.
// Depends on utf8sd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_unit_defines.svh"

module utf8sd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  utf8sd_pkg::tok_t       push_tok,
  output logic                   full,
  input  wire logic              pop,
  output utf8sd_pkg::tok_t       pop_tok,
  output logic                   empty
);
  import utf8sd_pkg::*;

  tok_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign full    = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_tok = mem[rd_ptr];

  // Store tokens
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `UTF8SD_ASSERT_IMP(a_no_overflow, clk, rst, push, !full || pop)
  `UTF8SD_ASSERT_IMP(a_no_underflow, clk, rst, pop, !empty)
  `UTF8SD_ASSERT_NXT(a_level_bound, clk, rst, 1'b1, count <= QUEUE_CW'(QUEUE_DEPTH))

endmodule

`default_nettype wire

FILE: src/utf8sd_back.sv
// Back end: accumulates code points, keeps the character total, drives results.
// Depends on utf8sd_pkg; pops tokens from utf8sd_queue.
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  utf8sd_pkg::tok_t       q_tok,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [71:0]            m_tdata,   // [30:0] code_point, [46:31] code_unit,
                                            // [49:47] byte_count, [65:50] char_count
  output logic                   m_tuser    // [0] end_of_string
);
  import utf8sd_pkg::*;

  logic [CP_WIDTH-1:0]    acc;
  logic [CP_WIDTH-1:0]    acc_next;
  logic [2:0]             seq_len;
  logic [2:0]             seq_len_next;
  logic [COUNT_WIDTH-1:0] total;
  logic [COUNT_WIDTH-1:0] total_next;
  logic [COUNT_WIDTH-1:0] total_inc;
  logic [CP_WIDTH-1:0]    res_cp;
  logic [2:0]             res_len;
  logic [FIELD_WIDTH-1:0] res_cnt;
  logic                   res_end;
  logic                   is_end;

  assign q_pop     = !q_empty && (!m_tvalid || m_tready);
  assign is_end    = (q_tok.kind == TOK_END);
  assign total_inc = (total == {COUNT_WIDTH{1'b1}}) ? total : total + COUNT_WIDTH'(1);

  // Decode one token
  always_comb begin
    acc_next     = acc;
    seq_len_next = seq_len;
    total_next   = total;
    case (q_tok.kind)
      TOK_LEAD: begin
        acc_next     = {{(CP_WIDTH-7){1'b0}}, q_tok.payload};
        seq_len_next = q_tok.len;
      end
      TOK_CONT: begin
        acc_next = {acc[CP_WIDTH-7:0], q_tok.payload[5:0]};
      end
      TOK_END: begin
        acc_next     = '0;
        seq_len_next = 3'd0;
        total_next   = '0;
      end
      default: begin
        acc_next = acc;
      end
    endcase
    if (q_tok.last && !is_end) begin
      total_next = total_inc;
    end
    res_end = is_end;
    res_cp  = is_end ? '0 : acc_next;
    res_len = is_end ? 3'd0 : seq_len_next;
    res_cnt = is_end ? count_field(total) : count_field(total_inc);
  end

  // Update decode state on each popped token
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      seq_len <= 3'd0;
      total   <= '0;
    end else if (q_pop) begin
      acc     <= acc_next;
      seq_len <= seq_len_next;
      total   <= total_next;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= q_tok.last;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_tok.last) begin
      m_tdata <= {6'b0, res_cnt, res_len, res_cp[UNIT_WIDTH-1:0], res_cp};
      m_tuser <= res_end;
    end
  end

endmodule

`default_nettype wire

FILE: src/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder (six-byte form), one byte per cycle. A byte accepted on the
// input stream is classified in the same cycle and placed in a four-entry token
// queue; the decoder pops one token per cycle unless the output is stalled and
// registers its result, so a character passes the queue, then the output register.
// Throughput is one byte per cycle; it drops only while the output is stalled and
// the queue has filled. A 0x00 or 0xff lead byte yields an end-of-string result
// carrying the character total and clears that total. Depends on utf8sd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [30:0] code_point, [46:31] code_unit,
                                      // [49:47] byte_count, [65:50] char_count
  output logic             m_tuser    // [0] end_of_string
);
  import utf8sd_pkg::*;

  tok_t push_tok;
  tok_t pop_tok;
  logic push;
  logic pop;
  logic full;
  logic empty;

  // Classify incoming bytes
  utf8sd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (full),
    .q_push   (push),
    .q_tok    (push_tok)
  );

  // Decouple classifier from decoder
  utf8sd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .full     (full),
    .pop      (pop),
    .pop_tok  (pop_tok),
    .empty    (empty)
  );

  // Decode and drive results
  utf8sd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_tok    (pop_tok),
    .q_empty  (empty),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

FILE: sim/utf8_stream_decoder_unit_tb.sv
// Self-checking testbench for the UTF-8 stream decoder: a byte-level predictor inside a
// scoreboard class checks every output character against the decoded byte stream.
// Depends on utf8sd_pkg and utf8_stream_decoder_unit.
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_tb;
  import utf8sd_pkg::*;

  localparam int LATENCY_CYCLES = 20;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int RANDOM_BYTES   = 500;
  localparam int QUIET_BYTES    = 150;
  localparam int PRINT_LIMIT    = 100;

  localparam logic [COUNT_WIDTH-1:0] TOTAL_MAX = '1;

  // One decoded character or end-of-string marker
  typedef struct {
    bit [CP_WIDTH-1:0]   code_point;
    bit [UNIT_WIDTH-1:0] code_unit;
    bit [2:0]            byte_count;
    bit [15:0]           char_count;
    bit                  end_of_string;
  } char_result_t;

  // Decoder state mirror plus the queue of characters still owed by the block
  class utf8_char_scoreboard;
    char_result_t          expected_chars[$];
    bit [2:0]              bytes_left;
    bit [2:0]              seq_len;
    bit [CP_WIDTH-1:0]     acc;
    bit [COUNT_WIDTH-1:0]  char_total;
    int                    mismatches;

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("error at %0t: %s", $realtime, what);
    endtask

    function bit [15:0] clamped_total();
      longint unsigned t;
      t = longint'(char_total);
      return (t > 64'hffff) ? 16'hffff : 16'(t);
    endfunction

    function char_result_t char_done();
      char_result_t r;
      if (char_total != TOTAL_MAX) char_total++;
      r.code_point    = acc;
      r.code_unit     = acc[UNIT_WIDTH-1:0];
      r.byte_count    = seq_len;
      r.char_count    = clamped_total();
      r.end_of_string = 1'b0;
      return r;
    endfunction

    // Advance the decoder by one accepted byte
    function void note_byte(bit [7:0] b);
      char_result_t r;
      // Open sequence: any byte is a continuation
      if (bytes_left != 0) begin
        acc = {acc[CP_WIDTH-7:0], b[5:0]};
        bytes_left--;
        if (bytes_left == 0) expected_chars.push_back(char_done());
        return;
      end
      // String end on a lead position
      if (b == BYTE_NUL || b == BYTE_FF) begin
        r.code_point    = '0;
        r.code_unit     = '0;
        r.byte_count    = '0;
        r.char_count    = clamped_total();
        r.end_of_string = 1'b1;
        expected_chars.push_back(r);
        char_total = '0;
        seq_len    = '0;
        acc        = '0;
        return;
      end
      // Lead byte: length and payload mask from its value
      if (b < 8'h80) begin
        seq_len = 3'd1;
        acc     = CP_WIDTH'(b);
      end else if (b < 8'he0) begin
        seq_len = 3'd2;
        acc     = CP_WIDTH'(b & 8'h1f);
      end else if (b < 8'hf0) begin
        seq_len = 3'd3;
        acc     = CP_WIDTH'(b & 8'h0f);
      end else if (b < 8'hf8) begin
        seq_len = 3'd4;
        acc     = CP_WIDTH'(b & 8'h07);
      end else if (b < 8'hfe) begin
        seq_len = 3'd5;
        acc     = CP_WIDTH'(b & 8'h03);
      end else begin
        seq_len = 3'd6;
        acc     = CP_WIDTH'(b & 8'h01);
      end
      bytes_left = seq_len - 3'd1;
      if (bytes_left == 0) expected_chars.push_back(char_done());
    endfunction

    // Compare one output transaction with the oldest owed character
    task check_result(bit [71:0] tdata, bit tuser);
      char_result_t want;
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h tuser=%b", tdata, tuser));
        return;
      end
      want = expected_chars.pop_front();
      if (tdata[30:0] != want.code_point)
        report_mismatch($sformatf("code_point %h, want %h", tdata[30:0], want.code_point));
      if (tdata[46:31] != want.code_unit)
        report_mismatch($sformatf("code_unit %h, want %h", tdata[46:31], want.code_unit));
      if (tdata[49:47] != want.byte_count)
        report_mismatch($sformatf("byte_count %0d, want %0d", tdata[49:47], want.byte_count));
      if (tdata[65:50] != want.char_count)
        report_mismatch($sformatf("char_count %0d, want %0d", tdata[65:50], want.char_count));
      if (tuser != want.end_of_string)
        report_mismatch($sformatf("end_of_string %b, want %b", tuser, want.end_of_string));
    endtask

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tuser;

  utf8_char_scoreboard sb;
  bit                  quiet = 1'b0;
  int                  bytes_sent = 0;
  int                  cycles = 0;

  // ASCII, string end, stray continuation as lead, every sequence length,
  // 0x00/0xff and non-10xxxxxx bytes inside an open sequence
  bit [7:0] directed_bytes[] = '{
    8'h41, 8'h7f, 8'h00,
    8'hc3, 8'ha9,
    8'h80, 8'hbf,
    8'he2, 8'h82, 8'hac,
    8'hf0, 8'h9f, 8'h98, 8'h80,
    8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf,
    8'hfe, 8'hff, 8'h00, 8'h3f, 8'h7f, 8'hc0,
    8'hff
  };

  utf8_stream_decoder_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit take_gap();
    return !quiet && ($urandom_range(99) < 7);
  endfunction

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check output transactions, stall the output at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    m_tready <= !take_gap();
  end

  // Present one byte and hold it until the transaction completes
  task automatic send_byte(bit [7:0] b);
    while (take_gap()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Hold the input until every owed character has come out
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed sequences with random payload, some ends and noise
  task automatic send_random_sequence();
    int unsigned pick;
    int unsigned len;
    bit [7:0]    lead;
    pick = $urandom_range(99);
    if (pick < 6) begin
      send_byte($urandom_range(1) ? BYTE_FF : BYTE_NUL);
      return;
    end
    if (pick < 12) begin
      send_byte(8'($urandom_range(255)));
      return;
    end
    len = $urandom_range(1, 6);
    case (len)
      1: lead = 8'($urandom_range(8'h01, 8'h7f));
      2: lead = ($urandom_range(99) < 20) ? 8'($urandom_range(8'h80, 8'hbf))
                                          : 8'($urandom_range(8'hc0, 8'hdf));
      3: lead = 8'($urandom_range(8'he0, 8'hef));
      4: lead = 8'($urandom_range(8'hf0, 8'hf7));
      5: lead = 8'($urandom_range(8'hf8, 8'hfd));
      default: lead = 8'hfe;
    endcase
    send_byte(lead);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(99) < 90) send_byte({2'b10, 6'($urandom_range(63))});
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int start_count;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    wait_for_drain();

    // Random phase, opening with a stretch free of stalls
    start_count = bytes_sent;
    quiet = 1'b1;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      if (bytes_sent - start_count >= QUIET_BYTES) quiet = 1'b0;
      send_random_sequence();
    end
    wait_for_drain();

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/utf8sd_pkg.sv
src/utf8sd_front.sv
src/utf8sd_queue.sv
src/utf8sd_back.sv
src/utf8_stream_decoder_unit.sv
sim/utf8_stream_decoder_unit_tb.sv
